>>> sv/btop_pkg.sv
`default_nettype none
package btop_pkg;

   localparam int unsigned MAX_LEVELS_DEFAULT = 256;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] SPOT_RESET = 32'd6553600;
   localparam logic [31:0] UP_RESET = 32'h4000_0000;
   localparam logic [30:0] DOWN_RESET = 31'h4000_0000;
   localparam logic [30:0] PROB_RESET = 31'h2000_0000;
   localparam logic [30:0] DISC_RESET = 31'h4000_0000;
   localparam logic [8:0] LEVEL_RESET = 9'd1;

   localparam logic [2:0] CSR_SPOT = 3'd0;
   localparam logic [2:0] CSR_UP = 3'd1;
   localparam logic [2:0] CSR_DOWN = 3'd2;
   localparam logic [2:0] CSR_PROB = 3'd3;
   localparam logic [2:0] CSR_DISC = 3'd4;
   localparam logic [2:0] CSR_LEVEL = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT,
      ST_BU_RD, ST_BU_MUL, ST_BU_WR,
      ST_BD_RD, ST_BD_MUL, ST_BD_WR,
      ST_PAY_RD, ST_PAY_WR,
      ST_FLD_RD1, ST_FLD_RD2, ST_FLD_M2, ST_FLD_SUM, ST_FLD_DISC, ST_FLD_WR,
      ST_OUT_RD, ST_OUT_WAIT
   } state_type;

   typedef enum logic [2:0] {
      MB_UP, MB_DOWN, MB_PROB, MB_NPROB, MB_DISC
   } mul_sel_type;

   typedef enum logic [1:0] {
      WR_SPOT, WR_PROD, WR_PAYOFF
   } wr_sel_type;

   typedef struct packed {
      logic        take_req;
      logic        rd_en;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        mul_en;
      logic        mul_a_v;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        v_load;
      logic        out_load;
   } cmd_type;

endpackage
`default_nettype wire

>>> sv/binomial_tree_option_pricer_unit.sv
// Channel  Direction  Handshake        Word
// req      in         req_valid/stall  option_kind, strike_price
// rsp      out        rsp_valid/stall  option_price, saturated
// csr      in         csr_valid/ready  csr_index, csr_data (always ready)
// One request at a time; how long a request takes is set by the single node memory
// port and the one shared multiplier.
// Reset is synchronous; it restores the register defaults, node memory is not cleared.
// A stalled result waits in the output register; the next request is accepted meanwhile.
`default_nettype none
module binomial_tree_option_pricer_unit
   import btop_pkg::*;
#(
   parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_option_kind,
   input  wire logic [31:0]            req_strike_price,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_option_price,
   output logic                        rsp_saturated,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);
   localparam int unsigned AW = $clog2(MAX_LEVELS);

   cmd_type       cmd;
   logic [AW-1:0] rd_addr, wr_addr, last_idx;
   logic          out_free, busy;

   assign req_stall = busy;
   assign csr_ready = 1'b1;

   btop_controller #(.MAX_LEVELS(MAX_LEVELS), .AW(AW)) u_ctrl (
      .clock(clock), .reset(reset),
      .start(req_valid), .busy(busy),
      .last_idx(last_idx), .out_free(out_free),
      .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr)
   );

   btop_datapath #(.MAX_LEVELS(MAX_LEVELS), .AW(AW)) u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
      .last_idx(last_idx), .out_free(out_free),
      .req_option_kind(req_option_kind), .req_strike_price(req_strike_price),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_option_price(rsp_option_price), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data)
   );

endmodule
`default_nettype wire

>>> sv/btop_datapath.sv
`default_nettype none
module btop_datapath
   import btop_pkg::*;
#(
   parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEFAULT,
   parameter int unsigned AW = $clog2(MAX_LEVELS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   input  wire logic [AW-1:0]          rd_addr,
   input  wire logic [AW-1:0]          wr_addr,
   output logic [AW-1:0]               last_idx,
   output logic                        out_free,
   input  wire logic                   req_option_kind,
   input  wire logic [31:0]            req_strike_price,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_option_price,
   output logic                        rsp_saturated,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);
   localparam int unsigned LW = $clog2(MAX_LEVELS + 1);
   localparam int unsigned CW = (LW > 9) ? LW : 9;

   logic [31:0] spot_ff, up_ff;
   logic [30:0] down_ff, prob_ff, disc_ff;
   logic [8:0]  level_ff;
   logic [31:0] mem [MAX_LEVELS];
   logic [31:0] rdata_ff, strike_ff, v_ff, price_ff;
   logic        put_ff, clip_ff, valid_ff, sat_ff;
   logic [63:0] prod_ff, acc_ff, sum, prod_in;
   logic [64:0] rnd_sum;
   logic [34:0] rnd;
   logic        over, sat_use;
   logic [31:0] satv, a_mux, b_mux, payoff, wdata;
   logic [30:0] q_eff;
   logic [CW-1:0] lv;

   always_ff @(posedge clock) begin
      if (reset) begin
         spot_ff <= SPOT_RESET;
         up_ff <= UP_RESET;
         down_ff <= DOWN_RESET;
         prob_ff <= PROB_RESET;
         disc_ff <= DISC_RESET;
         level_ff <= LEVEL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SPOT: spot_ff <= csr_data;
            CSR_UP: up_ff <= csr_data;
            CSR_DOWN: down_ff <= csr_data[30:0];
            CSR_PROB: prob_ff <= csr_data[30:0];
            CSR_DISC: disc_ff <= csr_data[30:0];
            CSR_LEVEL: level_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lv = (level_ff == 9'd0) ? CW'(1) : CW'(level_ff);
      if (lv > CW'(MAX_LEVELS)) lv = CW'(MAX_LEVELS);
      last_idx = AW'(lv - CW'(1));
      q_eff = (prob_ff > ONE_Q30[30:0]) ? ONE_Q30[30:0] : prob_ff;
   end

   always_comb begin
      a_mux = cmd.mul_a_v ? v_ff : rdata_ff;
      case (cmd.mul_sel)
         MB_UP: b_mux = up_ff;
         MB_DOWN: b_mux = {1'b0, down_ff};
         MB_PROB: b_mux = {1'b0, q_eff};
         MB_NPROB: b_mux = {1'b0, ONE_Q30[30:0] - q_eff};
         MB_DISC: b_mux = {1'b0, disc_ff};
         default: b_mux = '0;
      endcase
      prod_in = {32'd0, a_mux} * {32'd0, b_mux};
      sum = cmd.acc_add ? acc_ff + prod_ff : prod_ff;
      rnd_sum = {1'b0, sum} + 65'(1 << 29);
      rnd = rnd_sum[64:30];
      over = |rnd[34:32];
      satv = over ? 32'hFFFF_FFFF : rnd[31:0];
      if (put_ff) payoff = (strike_ff > rdata_ff) ? strike_ff - rdata_ff : 32'd0;
      else payoff = (rdata_ff > strike_ff) ? rdata_ff - strike_ff : 32'd0;
      case (cmd.wr_sel)
         WR_SPOT: wdata = spot_ff;
         WR_PROD: wdata = satv;
         WR_PAYOFF: wdata = payoff;
         default: wdata = payoff;
      endcase
      sat_use = cmd.v_load || (cmd.wr_en && cmd.wr_sel == WR_PROD);
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[wr_addr] <= wdata;
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.acc_load) acc_ff <= prod_ff;
      if (cmd.v_load) v_ff <= satv;
      if (cmd.take_req) begin
         strike_ff <= req_strike_price;
         put_ff <= req_option_kind;
      end
      if (cmd.out_load) begin
         price_ff <= rdata_ff;
         sat_ff <= clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.take_req) clip_ff <= 1'b0;
         else if (sat_use && over) clip_ff <= 1'b1;
         if (cmd.out_load) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   assign out_free = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_option_price = price_ff;
   assign rsp_saturated = sat_ff;

endmodule
`default_nettype wire

>>> sv/btop_controller.sv
`default_nettype none
module btop_controller
   import btop_pkg::*;
#(
   parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEFAULT,
   parameter int unsigned AW = $clog2(MAX_LEVELS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [AW-1:0] last_idx,
   input  wire logic          out_free,
   output cmd_type            cmd,
   output logic [AW-1:0]      rd_addr,
   output logic [AW-1:0]      wr_addr
);
   state_type state_ff, state_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      cmd = '0;
      cmd.wr_sel = WR_PROD;
      cmd.mul_sel = MB_UP;
      rd_addr = j_ff;
      wr_addr = j_ff;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.take_req = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_SPOT;
            wr_addr = '0;
            i_in = AW'(1);
            j_in = '0;
            state_in = (last_idx == '0) ? ST_PAY_RD : ST_BU_RD;
         end
         ST_BU_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr = i_ff - AW'(1);
            state_in = ST_BU_MUL;
         end
         ST_BU_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MB_UP;
            state_in = ST_BU_WR;
         end
         ST_BU_WR: begin
            cmd.wr_en = 1'b1;
            wr_addr = i_ff;
            j_in = '0;
            state_in = ST_BD_RD;
         end
         ST_BD_RD: begin
            cmd.rd_en = 1'b1;
            state_in = ST_BD_MUL;
         end
         ST_BD_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MB_DOWN;
            state_in = ST_BD_WR;
         end
         ST_BD_WR: begin
            cmd.wr_en = 1'b1;
            if (j_ff == i_ff - AW'(1)) begin
               j_in = '0;
               if (i_ff == last_idx) state_in = ST_PAY_RD;
               else begin
                  i_in = i_ff + AW'(1);
                  state_in = ST_BU_RD;
               end
            end else begin
               j_in = j_ff + AW'(1);
               state_in = ST_BD_RD;
            end
         end
         ST_PAY_RD: begin
            cmd.rd_en = 1'b1;
            state_in = ST_PAY_WR;
         end
         ST_PAY_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_PAYOFF;
            if (j_ff == last_idx) begin
               j_in = '0;
               i_in = last_idx;
               state_in = (last_idx == '0) ? ST_OUT_RD : ST_FLD_RD1;
            end else begin
               j_in = j_ff + AW'(1);
               state_in = ST_PAY_RD;
            end
         end
         ST_FLD_RD1: begin
            cmd.rd_en = 1'b1;
            rd_addr = j_ff + AW'(1);
            state_in = ST_FLD_RD2;
         end
         ST_FLD_RD2: begin
            // multiply the up node while the down node is read
            cmd.rd_en = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MB_PROB;
            state_in = ST_FLD_M2;
         end
         ST_FLD_M2: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MB_NPROB;
            state_in = ST_FLD_SUM;
         end
         ST_FLD_SUM: begin
            cmd.acc_add = 1'b1;
            cmd.v_load = 1'b1;
            state_in = ST_FLD_DISC;
         end
         ST_FLD_DISC: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a_v = 1'b1;
            cmd.mul_sel = MB_DISC;
            state_in = ST_FLD_WR;
         end
         ST_FLD_WR: begin
            cmd.wr_en = 1'b1;
            if (j_ff == i_ff - AW'(1)) begin
               j_in = '0;
               if (i_ff == AW'(1)) state_in = ST_OUT_RD;
               else begin
                  i_in = i_ff - AW'(1);
                  state_in = ST_FLD_RD1;
               end
            end else begin
               j_in = j_ff + AW'(1);
               state_in = ST_FLD_RD1;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr = '0;
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            // hold the root word until the output register frees up
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == ST_IDLE) |=> state_ff == ST_INIT)
      else $error("request not taken into init");
   a_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result loaded over a pending word");
   a_port: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.rd_en)
      else $error("read and write in one cycle");
   a_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLD_RD1) |-> (j_ff < i_ff))
      else $error("fold index out of level");
`endif

endmodule
`default_nettype wire
